FILE: hw/rtl/crst_pkg.sv
// crst_pkg: types, constants and ring tables for the calorimeter ring-sum trigger
// used by every module of the block; no dependencies
`default_nettype none

package crst_pkg;

    // field widths
    localparam int RING_W    = 5;
    localparam int CELL_E_W  = 16;
    localparam int CLUS_W    = 6;
    localparam int SUM_W     = 26;
    localparam int WORD_W    = 11;
    localparam int CFG_IDX_W = 2;

    // build constants
    localparam int ENERGY_BITS = 16;
    localparam int MAX_CELLS   = 576;
    localparam int CNT_W       = $clog2(MAX_CELLS + 1);

    localparam logic [CELL_E_W-1:0] ENERGY_MASK =
        CELL_E_W'((64'd1 << ENERGY_BITS) - 64'd1);

    localparam int NUM_RINGS  = 17;
    localparam int NUM_COMBOS = 11;
    localparam int TOTAL_LO   = 1;
    localparam int TOTAL_MID  = 7;
    localparam int TOTAL_HI   = 14;

    // up to six rings in a combination, seven in each half of the total
    localparam int COMBO_W = SUM_W + 3;
    localparam int HALF_W  = SUM_W + 3;
    localparam int TOTAL_W = SUM_W + 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // ring membership of each bhabha combination
    localparam logic [NUM_RINGS-1:0] COMBO_RINGS [NUM_COMBOS] = '{
        17'b1_1000_0000_0000_0011,
        17'b1_1110_0000_0000_0110,
        17'b0_0000_0000_0000_0010,
        17'b0_0111_0000_0000_0100,
        17'b0_0001_1000_0000_1000,
        17'b0_0000_1000_0001_1000,
        17'b0_0000_1100_0001_0000,
        17'b0_0000_0110_0010_0000,
        17'b0_0000_0011_0100_0000,
        17'b0_0000_0001_1000_0000,
        17'b0_0001_0000_0000_0000
    };

    // trigger word bit positions
    localparam int TW_TOTAL  = 1;
    localparam int TW_BHABHA = 3;
    localparam int TW_CLUS_L = 5;
    localparam int TW_CLUS_H = 7;
    localparam int TW_FWD    = 8;
    localparam int TW_VETO   = 9;
    localparam int TW_ALWAYS = 10;

    localparam logic [CLUS_W-1:0] CLUS_SAT = CLUS_W'(7);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BHABHA_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUS_MIN   = 2'd2;

    localparam logic [SUM_W-1:0]  RST_TOTAL_THR  = 26'd1000;
    localparam logic [SUM_W-1:0]  RST_BHABHA_THR = 26'd5000;
    localparam logic [CLUS_W-1:0] RST_CLUS_MIN   = 6'd4;

    // queue between front and back
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    typedef struct packed {
        logic [RING_W-1:0]   ring_index;
        logic [CELL_E_W-1:0] cell_energy;
        logic                last_cell;
        logic [CLUS_W-1:0]   cluster_count;
        logic [CLUS_W-1:0]   forward_clusters;
        logic                background_veto;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] trigger_word;
        logic [SUM_W-1:0]  total_energy;
        logic              bhabha_star;
    } t_out;

    typedef struct packed {
        logic [SUM_W-1:0]  total_thr;
        logic [SUM_W-1:0]  bhabha_thr;
        logic [CLUS_W-1:0] clus_min;
    } t_cfg;

    // classified item as queued for the back end
    typedef struct packed {
        logic                add;
        logic [RING_W-1:0]   ring;
        logic [CELL_E_W-1:0] energy;
        logic                last;
        logic [CLUS_W-1:0]   clusters;
        logic [CLUS_W-1:0]   fwd;
        logic                veto;
    } t_qent;

endpackage

`default_nettype wire

FILE: hw/rtl/crst_front.sv
// crst_front: accepts cell items, counts cells per event and marks which ones add
// depends on crst_pkg
`default_nettype none

module crst_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  crst_pkg::t_in       i_in_data,
    input  wire logic           i_q_full,
    output logic                o_push,
    output crst_pkg::t_qent     o_qent
);

    logic [crst_pkg::CNT_W-1:0] r_cnt;
    logic [crst_pkg::CNT_W-1:0] n_cnt;
    logic                       room;

    assign o_push = i_in_valid && !i_q_full;
    assign room   = r_cnt < crst_pkg::CNT_W'(crst_pkg::MAX_CELLS);

    always_comb begin
        o_qent.add      = room &&
            (i_in_data.ring_index < crst_pkg::RING_W'(crst_pkg::NUM_RINGS));
        o_qent.ring     = i_in_data.ring_index;
        o_qent.energy   = i_in_data.cell_energy & crst_pkg::ENERGY_MASK;
        o_qent.last     = i_in_data.last_cell;
        o_qent.clusters = i_in_data.cluster_count;
        o_qent.fwd      = i_in_data.forward_clusters;
        o_qent.veto     = i_in_data.background_veto;
    end

    // cells past the limit still count toward closing the event
    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_in_data.last_cell) begin
                n_cnt = '0;
            end else if (room) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crst_queue.sv
// crst_queue: short fifo of classified items between front and back
// depends on crst_pkg
`default_nettype none

module crst_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  crst_pkg::t_qent     i_wdata,
    input  wire logic           i_pop,
    output crst_pkg::t_qent     o_rdata,
    output logic                o_full,
    output logic                o_empty
);

    crst_pkg::t_qent                r_mem [crst_pkg::QDEPTH];
    logic [crst_pkg::QPTR_BITS-1:0] r_wp;
    logic [crst_pkg::QPTR_BITS-1:0] r_rp;
    logic [crst_pkg::QPTR_BITS:0]   r_cnt;
    logic                           do_pop;

    assign o_full  = r_cnt == (crst_pkg::QPTR_BITS+1)'(crst_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crst_back.sv
// crst_back: ring sum accumulation, event evaluation and the result register
// depends on crst_pkg
`default_nettype none

module crst_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  crst_pkg::t_cfg      i_cfg,
    input  crst_pkg::t_qent     i_qent,
    input  wire logic           i_q_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output crst_pkg::t_out      o_out_data
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                    r_state;
    logic [crst_pkg::SUM_W-1:0]    r_sum [crst_pkg::NUM_RINGS];
    logic [crst_pkg::CLUS_W-1:0]   r_clusters;
    logic [crst_pkg::CLUS_W-1:0]   r_fwd;
    logic                          r_veto;
    logic [crst_pkg::HALF_W-1:0]   r_half_lo;
    logic [crst_pkg::HALF_W-1:0]   r_half_hi;
    logic [crst_pkg::COMBO_W-1:0]  r_combo [crst_pkg::NUM_COMBOS];
    logic                          r_out_valid;
    crst_pkg::t_out                r_out;

    logic [crst_pkg::SUM_W:0]      acc;
    logic [crst_pkg::SUM_W-1:0]    n_ring;
    logic [crst_pkg::HALF_W-1:0]   n_half_lo;
    logic [crst_pkg::HALF_W-1:0]   n_half_hi;
    logic [crst_pkg::COMBO_W-1:0]  n_combo [crst_pkg::NUM_COMBOS];
    logic [crst_pkg::TOTAL_W-1:0]  total;
    logic                          star;
    logic                          out_free;
    logic                          load;
    crst_pkg::t_out                n_out;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == ST_RUN) && !i_q_empty;
    assign load        = (r_state == ST_DONE) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // saturating add into the item's ring
    always_comb begin
        acc    = {1'b0, r_sum[i_qent.ring]} + (crst_pkg::SUM_W+1)'(i_qent.energy);
        n_ring = acc[crst_pkg::SUM_W] ? crst_pkg::SUM_MAX : acc[crst_pkg::SUM_W-1:0];
    end

    // first evaluation step: half totals and combination sums
    always_comb begin
        n_half_lo = '0;
        n_half_hi = '0;
        for (int r = crst_pkg::TOTAL_LO; r <= crst_pkg::TOTAL_MID; r++) begin
            n_half_lo = n_half_lo + crst_pkg::HALF_W'(r_sum[r]);
        end
        for (int r = crst_pkg::TOTAL_MID + 1; r <= crst_pkg::TOTAL_HI; r++) begin
            n_half_hi = n_half_hi + crst_pkg::HALF_W'(r_sum[r]);
        end
        for (int c = 0; c < crst_pkg::NUM_COMBOS; c++) begin
            n_combo[c] = '0;
            for (int r = 0; r < crst_pkg::NUM_RINGS; r++) begin
                if (crst_pkg::COMBO_RINGS[c][r]) begin
                    n_combo[c] = n_combo[c] + crst_pkg::COMBO_W'(r_sum[r]);
                end
            end
        end
    end

    // second step: total, compares and the trigger word
    always_comb begin
        total = crst_pkg::TOTAL_W'(r_half_lo) + crst_pkg::TOTAL_W'(r_half_hi);
        star  = 1'b0;
        for (int c = 0; c < crst_pkg::NUM_COMBOS; c++) begin
            if (r_combo[c] > crst_pkg::COMBO_W'(i_cfg.bhabha_thr)) begin
                star = 1'b1;
            end
        end
        n_out.trigger_word = '0;
        n_out.trigger_word[crst_pkg::TW_TOTAL] =
            total > crst_pkg::TOTAL_W'(i_cfg.total_thr);
        n_out.trigger_word[crst_pkg::TW_BHABHA] = star && (r_clusters > i_cfg.clus_min);
        n_out.trigger_word[crst_pkg::TW_CLUS_H:crst_pkg::TW_CLUS_L] =
            (r_clusters >= crst_pkg::CLUS_SAT) ? crst_pkg::CLUS_SAT[2:0] : r_clusters[2:0];
        n_out.trigger_word[crst_pkg::TW_FWD]    = r_fwd != '0;
        n_out.trigger_word[crst_pkg::TW_VETO]   = r_veto;
        n_out.trigger_word[crst_pkg::TW_ALWAYS] = 1'b1;
        n_out.total_energy = (total > crst_pkg::TOTAL_W'(crst_pkg::SUM_MAX)) ?
            crst_pkg::SUM_MAX : total[crst_pkg::SUM_W-1:0];
        n_out.bhabha_star  = star;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
            for (int r = 0; r < crst_pkg::NUM_RINGS; r++) begin
                r_sum[r] <= '0;
            end
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_RUN: begin
                    if (o_pop) begin
                        if (i_qent.add) begin
                            r_sum[i_qent.ring] <= n_ring;
                        end
                        if (i_qent.last) begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (load) begin
                        for (int r = 0; r < crst_pkg::NUM_RINGS; r++) begin
                            r_sum[r] <= '0;
                        end
                        r_state <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop && i_qent.last) begin
            r_clusters <= i_qent.clusters;
            r_fwd      <= i_qent.fwd;
            r_veto     <= i_qent.veto;
        end
        if (r_state == ST_SUM) begin
            r_half_lo <= n_half_lo;
            r_half_hi <= n_half_hi;
            for (int c = 0; c < crst_pkg::NUM_COMBOS; c++) begin
                r_combo[c] <= n_combo[c];
            end
        end
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/calorimeter_ring_sum_trigger_top.sv
// calorimeter_ring_sum_trigger_top: top level, configuration registers and wiring
// depends on crst_pkg, crst_front, crst_queue, crst_back
`default_nettype none

// Takes one cell item per cycle while the four-entry item queue has room. Cells
// that are not last produce no result; the accumulator adds them into their ring.
// The last cell of an event passes three back-end steps (accumulate, combination
// sums, total and compares) before its result lands in the output register;
// the queue keeps taking cells of the next event during that evaluation. A result
// waiting on o_out_valid holds the back end in evaluation once the next result is
// ready to load; the input side stalls only when the queue then fills up.
// Configuration writes are registered and are read at event evaluation.
module calorimeter_ring_sum_trigger_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  crst_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output crst_pkg::t_out                      o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [crst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [crst_pkg::SUM_W-1:0]     i_cfg_wdata
);

    crst_pkg::t_cfg  r_cfg;
    crst_pkg::t_qent push_ent;
    crst_pkg::t_qent head_ent;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    assign o_in_stall = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_thr  <= crst_pkg::RST_TOTAL_THR;
            r_cfg.bhabha_thr <= crst_pkg::RST_BHABHA_THR;
            r_cfg.clus_min   <= crst_pkg::RST_CLUS_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crst_pkg::CFG_TOTAL_THR:  r_cfg.total_thr  <= i_cfg_wdata;
                crst_pkg::CFG_BHABHA_THR: r_cfg.bhabha_thr <= i_cfg_wdata;
                crst_pkg::CFG_CLUS_MIN:
                    r_cfg.clus_min <= i_cfg_wdata[crst_pkg::CLUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    crst_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_qent     (push_ent)
    );

    crst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_ent),
        .i_pop   (pop),
        .o_rdata (head_ent),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    crst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_qent      (head_ent),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/crst_checker.sv
// crst_checker: port-level assertions for the ring-sum trigger, bound to the top
// depends on crst_pkg and calorimeter_ring_sum_trigger_top
`default_nettype none

module crst_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     o_in_stall,
    input  crst_pkg::t_in i_in_data,
    input  wire logic     o_out_valid,
    input  wire logic     i_out_stall,
    input  crst_pkg::t_out o_out_data
);

    // a stalled input item stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input item changed while stalled");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // fixed bits of the trigger word
    a_word_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.trigger_word[crst_pkg::TW_ALWAYS] &&
            !o_out_data.trigger_word[0] && !o_out_data.trigger_word[2] &&
            !o_out_data.trigger_word[4])
        else $error("fixed trigger word bits wrong");

    // bhabha bit needs some combination above threshold
    a_bhabha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trigger_word[crst_pkg::TW_BHABHA] |->
            o_out_data.bhabha_star)
        else $error("bhabha bit without star");

    // total bit needs some energy
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trigger_word[crst_pkg::TW_TOTAL] |->
            o_out_data.total_energy != '0)
        else $error("total bit with zero energy");

endmodule

bind calorimeter_ring_sum_trigger_top crst_checker u_crst_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for calorimeter_ring_sum_trigger_top, predicts every trigger word
// from its own copy of the ring sums and thresholds; drives gaps, stalls and register writes
// depends on crst_pkg and the block's RTL

module tb;
    import crst_pkg::*;

    localparam int RING_COUNT     = 17;
    localparam int COMBO_COUNT    = 11;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [SUM_W-1:0]     RING_SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CELL_E_W-1:0]  CELL_MASK     = CELL_E_W'((64'd1 << ENERGY_BITS) - 64'd1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [SUM_W-1:0]     DEF_TOTAL_THR = 26'd1000;
    localparam logic [SUM_W-1:0]     DEF_BHABHA    = 26'd5000;
    localparam logic [CLUS_W-1:0]    DEF_CLUS_MIN  = 6'd4;

    // trigger word bit positions
    localparam int WB_TOTAL  = 1;
    localparam int WB_BHABHA = 3;
    localparam int WB_CLUS   = 5;
    localparam int WB_FWD    = 8;
    localparam int WB_VETO   = 9;
    localparam int WB_MARK   = 10;

    // bhabha combinations, bit n set for ring n
    localparam logic [RING_COUNT-1:0] BHABHA_COMBOS [COMBO_COUNT] = '{
        17'h18003,  // 0 1 15 16
        17'h1E006,  // 1 2 13 14 15 16
        17'h00002,  // 1
        17'h07004,  // 2 12 13 14
        17'h01808,  // 3 11 12
        17'h00818,  // 3 4 11
        17'h00C10,  // 4 10 11
        17'h00620,  // 5 9 10
        17'h00340,  // 6 8 9
        17'h00180,  // 7 8
        17'h01000   // 12
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [SUM_W-1:0]     i_cfg_wdata = '0;

    // predictor state
    logic [SUM_W-1:0]  ring_energy [RING_COUNT];
    int unsigned       cells_in_event;
    logic [SUM_W-1:0]  thr_total;
    logic [SUM_W-1:0]  thr_bhabha;
    logic [CLUS_W-1:0] min_clusters;
    t_out              trigger_expected [$];
    t_out              want;

    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          mismatches      = 0;
    int          words_checked   = 0;
    int          cells_sent      = 0;
    int unsigned quiet_cycles    = 0;

    calorimeter_ring_sum_trigger_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_event();
        for (int n = 0; n < RING_COUNT; n++)
            ring_energy[n] = '0;
        cells_in_event = 0;
    endfunction

    // accumulate one cell; on the last cell of an event build the trigger result
    function automatic bit predict_cell(input t_in c, output t_out r);
        logic [SUM_W:0] grown;
        logic [31:0]    total;
        logic [31:0]    combo;
        logic           star;
        r     = '0;
        total = '0;
        star  = 1'b0;
        if (cells_in_event < MAX_CELLS) begin
            if (c.ring_index < RING_COUNT) begin
                grown = (SUM_W+1)'(ring_energy[c.ring_index]) +
                        (SUM_W+1)'(c.cell_energy & CELL_MASK);
                ring_energy[c.ring_index] = (grown > (SUM_W+1)'(RING_SUM_MAX)) ? RING_SUM_MAX
                                                                   : grown[SUM_W-1:0];
            end
            cells_in_event++;
        end
        if (!c.last_cell)
            return 1'b0;
        for (int n = 1; n <= 14; n++)
            total += 32'(ring_energy[n]);
        for (int k = 0; k < COMBO_COUNT; k++) begin
            combo = '0;
            for (int n = 0; n < RING_COUNT; n++)
                if (BHABHA_COMBOS[k][n])
                    combo += 32'(ring_energy[n]);
            if (combo > 32'(thr_bhabha))
                star = 1'b1;
        end
        r.trigger_word[WB_MARK]      = 1'b1;
        r.trigger_word[WB_TOTAL]     = total > 32'(thr_total);
        r.trigger_word[WB_BHABHA]    = star && (c.cluster_count > min_clusters);
        r.trigger_word[WB_CLUS +: 3] = (c.cluster_count >= 7) ? 3'd7 : c.cluster_count[2:0];
        r.trigger_word[WB_FWD]       = c.forward_clusters != '0;
        r.trigger_word[WB_VETO]      = c.background_veto;
        r.total_energy = (total > 32'(RING_SUM_MAX)) ? RING_SUM_MAX : total[SUM_W-1:0];
        r.bhabha_star  = star;
        clear_event();
        return 1'b1;
    endfunction

    function automatic t_in random_cell(input bit last);
        t_in c;
        c.ring_index = ($urandom_range(9) == 0) ? RING_W'($urandom_range(31, 17))
                                                : RING_W'($urandom_range(16));
        case ($urandom_range(3))
            0: begin
                c.cell_energy = CELL_E_W'($urandom_range(255));
            end
            1: begin
                c.cell_energy = CELL_E_W'($urandom_range(20000, 1000));
            end
            2: begin
                c.cell_energy = ($urandom_range(1) == 1) ? {CELL_E_W{1'b1}} : {CELL_E_W{1'b0}};
            end
            default: begin
                c.cell_energy = CELL_E_W'($urandom);
            end
        endcase
        c.last_cell        = last;
        c.cluster_count    = ($urandom_range(1) == 1) ? CLUS_W'($urandom_range(9))
                                                      : CLUS_W'($urandom);
        c.forward_clusters = ($urandom_range(2) == 0) ? '0 : CLUS_W'($urandom);
        c.background_veto  = 1'($urandom_range(1));
        return c;
    endfunction

    // cluster minimum with junk above the six bits the register keeps
    function automatic logic [SUM_W-1:0] clus_word(input int m);
        return (SUM_W'($urandom) << CLUS_W) | SUM_W'(m);
    endfunction

    task automatic send_cell(input t_in c);
        t_out r;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        cells_sent++;
        if (predict_cell(c, r))
            trigger_expected.push_back(r);
    endtask

    task automatic send_fields(input int ring, input int energy, input bit last,
                               input int clus, input int fwd, input bit veto);
        t_in c;
        c.ring_index       = RING_W'(ring);
        c.cell_energy      = CELL_E_W'(energy);
        c.last_cell        = last;
        c.cluster_count    = CLUS_W'(clus);
        c.forward_clusters = CLUS_W'(fwd);
        c.background_veto  = veto;
        send_cell(c);
    endtask

    task automatic send_random_event();
        int n_cells;
        n_cells = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
        for (int k = 1; k <= n_cells; k++)
            send_cell(random_cell(k == n_cells));
    endtask

    // input off, all results taken, then let queued non-last items drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (trigger_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TOTAL_THR: begin
                thr_total = data;
            end
            CFG_BHABHA_THR: begin
                thr_bhabha = data;
            end
            CFG_CLUS_MIN: begin
                min_clusters = data[CLUS_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_thresholds(input logic [SUM_W-1:0] tot, input logic [SUM_W-1:0] bha,
                                  input logic [SUM_W-1:0] clus, input bit touch_spare);
        wait_idle();
        write_reg(CFG_TOTAL_THR, tot);
        write_reg(CFG_BHABHA_THR, bha);
        write_reg(CFG_CLUS_MIN, clus);
        // unmapped index must be ignored
        if (touch_spare)
            write_reg(CFG_SPARE, SUM_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_fields(5, 1000, 1, 5, 0, 0);   // total equal to threshold does not trip
        send_fields(5, 1001, 1, 5, 0, 0);
        send_fields(12, 5000, 1, 5, 0, 0);  // combination equal to threshold
        send_fields(12, 5001, 1, 4, 0, 0);  // star but cluster count not above minimum
        send_fields(12, 5001, 1, 5, 0, 0);
    endtask

    task automatic test_field_extremes();
        send_fields(0, 0, 1, 0, 0, 0);
        // event side fields on non-last items are ignored
        for (int n = 0; n < RING_COUNT; n++)
            send_fields(n, 65535, 0, 63, 63, 1);
        send_fields(17, 65535, 0, 63, 63, 1);  // out of range rings add nothing
        send_fields(31, 65535, 0, 0, 0, 0);
        send_fields(0, 0, 1, 63, 63, 1);
        send_fields(3, 65535, 1, 7, 1, 0);
        send_fields(0, 65535, 1, 6, 0, 1);     // ring 0 feeds combinations only
    endtask

    task automatic test_threshold_extremes();
        set_thresholds('0, '0, clus_word(0), 1'b0);
        sender_idle_pct = 17;
        stall_pct       = 17;
        send_fields(0, 0, 1, 1, 0, 0);
        send_fields(1, 1, 1, 1, 0, 0);
        send_fields(16, 1, 1, 0, 0, 0);
        repeat (6) send_random_event();
        set_thresholds(RING_SUM_MAX, RING_SUM_MAX, clus_word(63), 1'b1);
        send_fields(12, 65535, 1, 63, 63, 1);
        repeat (6) send_random_event();
    endtask

    // the cell at the limit still adds, the ten after it must not
    task automatic test_cell_limit();
        t_in c;
        set_thresholds(26'd500000, 26'd300000, clus_word(2), 1'b0);
        for (int k = 1; k <= MAX_CELLS + 10; k++) begin
            c = random_cell(k == MAX_CELLS + 10);
            if (k < MAX_CELLS) begin
                c.ring_index  = RING_W'($urandom_range(16));
                c.cell_energy = CELL_E_W'($urandom_range(255));
            end else begin
                c.ring_index  = (k == MAX_CELLS) ? RING_W'(5) : RING_W'(12);
                c.cell_energy = {CELL_E_W{1'b1}};
            end
            send_cell(c);
        end
        send_random_event();
    endtask

    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < 4; p++) begin
            set_thresholds(SUM_W'($urandom_range(250000)), SUM_W'($urandom_range(200000)),
                           clus_word($urandom_range(8)), p == 1);
            sender_idle_pct = (p == 1) ? 56 : (p == 3) ? 17 : 0;
            stall_pct       = (p == 2) ? 56 : (p == 3) ? 17 : 0;
            target = cells_sent + 100;
            while (cells_sent < target)
                send_random_event();
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (trigger_expected.size() == 0) begin
                $error("trigger word with no event pending: %h", o_out_data);
                mismatches++;
            end else begin
                want = trigger_expected.pop_front();
                words_checked++;
                if (o_out_data.trigger_word !== want.trigger_word) begin
                    $error("trigger_word: expected %h, got %h",
                           want.trigger_word, o_out_data.trigger_word);
                    mismatches++;
                end
                if (o_out_data.total_energy !== want.total_energy) begin
                    $error("total_energy: expected %0d, got %0d",
                           want.total_energy, o_out_data.total_energy);
                    mismatches++;
                end
                if (o_out_data.bhabha_star !== want.bhabha_star) begin
                    $error("bhabha_star: expected %b, got %b",
                           want.bhabha_star, o_out_data.bhabha_star);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout with %0d trigger words outstanding", trigger_expected.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        clear_event();
        thr_total    = DEF_TOTAL_THR;
        thr_bhabha   = DEF_BHABHA;
        min_clusters = DEF_CLUS_MIN;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_threshold_extremes();
        test_cell_limit();
        test_random_traffic();
        wait_idle();
        $display("%0d cells sent, %0d trigger words compared", cells_sent, words_checked);
        $display("reset defaults, threshold extremes, cell limit, four gap and stall mixes");
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
